// File: sv/lrw_pkg.sv
`timescale 1ns / 1ps
package lrw_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int MODE_W         = 2;
  localparam int INTEN_W        = 8;

  localparam logic [MODE_W-1:0] MODE_DDA  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BRES = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WU   = 2'd2;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MAIN,
    ST_SIDE
  } lrw_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_finish;
    logic step;
    logic sel_side;
  } lrw_cmd_t;

  typedef struct packed {
    logic active;
    logic zero_len;
    logic div_done;
    logic side_ok;
  } lrw_stat_t;

endpackage

// File: sv/lrw_ctrl.sv
`timescale 1ns / 1ps
module lrw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_action,
  input  logic             out_ready,
  input  lrw_pkg::lrw_stat_t stat,
  output logic             in_ready,
  output logic             out_valid,
  output lrw_pkg::lrw_cmd_t  cmd
);
  import lrw_pkg::*;

  lrw_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_START) begin
            state_next = stat.zero_len ? ST_IDLE : ST_DIV;
          end else if (stat.active) begin
            state_next = ST_MAIN;
          end
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_MAIN: begin
        if (out_ready) begin
          state_next = stat.side_ok ? ST_SIDE : ST_IDLE;
        end
      end
      ST_SIDE: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = (in_action == ACT_START);
          cmd.step = (in_action == ACT_STEP) && stat.active;
        end
      end
      ST_DIV: begin
        cmd.div_finish = stat.div_done;
        cmd.div_step   = !stat.div_done;
      end
      ST_MAIN: begin
        out_valid = 1'b1;
      end
      ST_SIDE: begin
        out_valid    = 1'b1;
        cmd.sel_side = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/lrw_datapath.sv
`timescale 1ns / 1ps
module lrw_datapath #(
  parameter int COORD_BITS = lrw_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lrw_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [lrw_pkg::MODE_W-1:0]    cfg_mode,
  input  logic signed [COORD_BITS-1:0]  delta_x,
  input  logic signed [COORD_BITS-1:0]  delta_y,
  input  lrw_pkg::lrw_cmd_t             cmd,
  output lrw_pkg::lrw_stat_t            stat,
  output logic [COORD_BITS:0]           pixel_x,
  output logic [COORD_BITS:0]           pixel_y,
  output logic [lrw_pkg::INTEN_W-1:0]   intensity,
  output logic                          last
);
  import lrw_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int PW   = CB + 1;
  localparam int AW   = CB + F + 1;
  localparam int IW   = F + 2;
  localparam int EW   = F + 4;
  localparam int NW   = CB + F;
  localparam int ITER = CB + F;
  localparam int CW   = $clog2(ITER + 1);

  localparam logic [F:0]    ONE_Q  = (F+1)'(1) << F;
  localparam logic [EW-1:0] ONE_E  = EW'(1) << F;
  localparam logic [EW-1:0] HALF_E = EW'(1) << (F - 1);

  logic [MODE_W-1:0] line_mode;
  logic              active;
  logic              x_major;
  logic              sx_neg, sy_neg;
  logic              p_neg, s_step_neg, s_delta_neg;
  logic [CB-1:0]     step_index, step_limit;
  logic [PW-1:0]     primary_pos, secondary_pos;
  logic [EW-1:0]     error_term;
  logic [F:0]        slope_frac;
  logic [AW-1:0]     dda_x_acc, dda_y_acc;
  logic [IW-1:0]     dda_x_inc, dda_y_inc;

  // Restoring divider, one quotient bit per cycle.
  logic [CB-1:0]     div_rem;
  logic [NW-1:0]     div_num;
  logic [F:0]        div_q;
  logic [CW-1:0]     div_cnt;

  logic [PW-1:0]      main_x, main_y, side_x, side_y;
  logic [INTEN_W-1:0] main_i, side_i;
  logic               main_last, side_ok;

  // Start decode.
  logic [CB-1:0] ax, ay, len, amin;
  logic          xm_in, zero_in, ds_neg, ds_zero;

  always_comb begin
    ax      = delta_x[CB-1] ? CB'(-delta_x) : CB'(delta_x);
    ay      = delta_y[CB-1] ? CB'(-delta_y) : CB'(delta_y);
    xm_in   = ax >= ay;
    len     = xm_in ? ax : ay;
    amin    = xm_in ? ay : ax;
    zero_in = (len == '0);
    ds_neg  = xm_in ? delta_y[CB-1] : delta_x[CB-1];
    ds_zero = xm_in ? (delta_y == '0) : (delta_x == '0);
  end

  logic [CB:0] trial;
  logic        trial_ge;
  logic [F:0]  ceil_q, mag_x, mag_y;

  always_comb begin
    trial    = {div_rem, div_num[NW-1]};
    trial_ge = trial >= {1'b0, step_limit};
    ceil_q   = div_q + {{F{1'b0}}, (div_rem != '0)};
    mag_x    = x_major ? ONE_Q : ceil_q;
    mag_y    = x_major ? ceil_q : ONE_Q;
  end

  function automatic logic [PW-1:0] trunc_px(input logic [AW-1:0] a);
    logic [AW-1:0] mag;
    logic [AW-1:0] t;
    mag = a[AW-1] ? -a : a;
    t   = mag >> F;
    return a[AW-1] ? PW'(-t) : PW'(t);
  endfunction

  // Step arithmetic.
  logic [MODE_W-1:0] mode_eff;
  logic [AW-1:0]     acc_x_n, acc_y_n;
  logic [EW-1:0]     err_abs;
  logic [F-1:0]      frac;
  logic [F:0]        one_m_f;
  logic [F+7:0]      prod_m;
  logic [F+8:0]      prod_s;
  logic              err_neg, last_now, side_now, off_neg;
  logic [PW-1:0]     p_cur, s_cur, s_side;
  logic [EW-1:0]     err_n;

  always_comb begin
    mode_eff = (line_mode == MODE_DDA || line_mode == MODE_BRES || line_mode == MODE_WU)
               ? line_mode : MODE_DDA;
    acc_x_n  = dda_x_acc + {{(AW-IW){dda_x_inc[IW-1]}}, dda_x_inc};
    acc_y_n  = dda_y_acc + {{(AW-IW){dda_y_inc[IW-1]}}, dda_y_inc};
    err_neg  = error_term[EW-1];
    err_abs  = err_neg ? -error_term : error_term;
    frac     = err_abs[F-1:0];
    one_m_f  = ONE_Q - {1'b0, frac};
    prod_m   = (F+8)'(frac) * (F+8)'(8'd255);
    prod_s   = (F+9)'(one_m_f) * (F+9)'(8'd255);
    p_cur    = primary_pos;
    s_cur    = secondary_pos;
    off_neg  = s_delta_neg ^ err_neg;
    s_side   = off_neg ? s_cur - PW'(1) : s_cur + PW'(1);
    if (mode_eff == MODE_DDA) begin
      last_now = ({1'b0, step_index} + (CB+1)'(1)) >= {1'b0, step_limit};
    end else begin
      last_now = step_index >= step_limit;
    end
    side_now = (mode_eff == MODE_WU) && (step_index != '0) && !last_now;
    err_n    = error_term - (err_neg ? '0 : ONE_E) + EW'(slope_frac);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_mode <= MODE_DDA;
      active    <= 1'b0;
      div_cnt   <= '0;
      side_ok   <= 1'b0;
    end else begin
      if (cfg_write) begin
        line_mode <= cfg_mode;
      end
      if (cmd.load) begin
        active  <= !zero_in;
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + CW'(1);
      end else if (cmd.step) begin
        active  <= !last_now;
        side_ok <= side_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_major       <= xm_in;
      sx_neg        <= delta_x[CB-1];
      sy_neg        <= delta_y[CB-1];
      p_neg         <= xm_in ? delta_x[CB-1] : delta_y[CB-1];
      s_step_neg    <= ds_neg || ds_zero;
      s_delta_neg   <= ds_neg;
      step_limit    <= len;
      step_index    <= '0;
      primary_pos   <= '0;
      secondary_pos <= '0;
      dda_x_acc     <= '0;
      dda_y_acc     <= '0;
      div_rem       <= '0;
      div_num       <= {amin, {F{1'b0}}};
      div_q         <= '0;
    end else if (cmd.div_step) begin
      div_rem <= trial_ge ? CB'(trial - {1'b0, step_limit}) : trial[CB-1:0];
      div_num <= div_num << 1;
      div_q   <= {div_q[F-1:0], trial_ge};
    end else if (cmd.div_finish) begin
      dda_x_inc  <= sx_neg ? -IW'(mag_x) : IW'(mag_x);
      dda_y_inc  <= sy_neg ? -IW'(mag_y) : IW'(mag_y);
      slope_frac <= div_q;
      error_term <= EW'(div_q) - HALF_E;
    end else if (cmd.step) begin
      dda_x_acc <= acc_x_n;
      dda_y_acc <= acc_y_n;
      if (mode_eff == MODE_DDA) begin
        main_x <= trunc_px(acc_x_n);
        main_y <= trunc_px(acc_y_n);
        main_i <= '0;
      end else begin
        main_x <= x_major ? p_cur : s_cur;
        main_y <= x_major ? s_cur : p_cur;
        main_i <= (mode_eff == MODE_WU) ? prod_m[F+7:F] : '0;
      end
      main_last <= last_now;
      side_x    <= x_major ? p_cur : s_side;
      side_y    <= x_major ? s_side : p_cur;
      side_i    <= prod_s[F+7:F];
      if (!err_neg) begin
        secondary_pos <= s_step_neg ? secondary_pos - PW'(1) : secondary_pos + PW'(1);
      end
      primary_pos <= p_neg ? primary_pos - PW'(1) : primary_pos + PW'(1);
      error_term  <= err_n;
      step_index  <= step_index + CB'(1);
    end
  end

  always_comb begin
    stat.active   = active;
    stat.zero_len = zero_in;
    stat.div_done = (div_cnt == CW'(ITER));
    stat.side_ok  = side_ok;
    pixel_x   = cmd.sel_side ? side_x : main_x;
    pixel_y   = cmd.sel_side ? side_y : main_y;
    intensity = cmd.sel_side ? side_i : main_i;
    last      = cmd.sel_side ? 1'b0 : main_last;
  end

endmodule

// File: sv/line_rasterizer_dda_bresenham_wu.sv
`timescale 1ns / 1ps
// Line rasterizer with DDA, Bresenham and Wu modes, selected by the mode register
// written on the cfg channel. A start beat (tuser 0) loads the line delta and then
// runs a restoring divider for the slope, one quotient bit per cycle, so the block
// takes no new beat until the divider has finished; a zero-length start is dropped
// and the block stays idle. Each step beat (tuser 1) gives one pixel beat out, or
// two when Wu adds a side pixel, and no new beat is taken until those are accepted.
// Pixels are relative to the line origin; step beats while no line is loaded
// produce nothing.
module line_rasterizer_dda_bresenham_wu #(
  parameter int COORD_BITS = lrw_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lrw_pkg::FRAC_BITS_DEF,
  parameter int IN_W       = ((2 * COORD_BITS + 7) / 8) * 8,
  parameter int OUT_W      = ((2 * (COORD_BITS + 1) + lrw_pkg::INTEN_W + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [IN_W-1:0]            s_axis_tdata,   // delta_x, delta_y
  input  logic                       s_axis_tuser,   // action
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [OUT_W-1:0]           m_axis_tdata,   // pixel_x, pixel_y, intensity
  output logic                       m_axis_tlast,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lrw_pkg::MODE_W-1:0] cfg_data        // line_mode
);
  import lrw_pkg::*;

  lrw_cmd_t            cmd;
  lrw_stat_t           stat;
  logic [COORD_BITS:0] px, py;
  logic [INTEN_W-1:0]  inten;

  assign cfg_ready = 1'b1;

  lrw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (s_axis_tuser),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .cmd       (cmd)
  );

  lrw_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_mode  (cfg_data),
    .delta_x   (s_axis_tdata[COORD_BITS-1:0]),
    .delta_y   (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .cmd       (cmd),
    .stat      (stat),
    .pixel_x   (px),
    .pixel_y   (py),
    .intensity (inten),
    .last      (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'({inten, py, px});

endmodule

// File: sv/lrw_checker.sv
`timescale 1ns / 1ps
module lrw_checker #(
  parameter int OUT_W = ((2 * (lrw_pkg::COORD_BITS_DEF + 1) + lrw_pkg::INTEN_W + 7) / 8) * 8
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       s_axis_tuser,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [OUT_W-1:0]           m_axis_tdata,
  input logic                       m_axis_tlast
);
  import lrw_pkg::*;

  // The block never takes a new beat while a pixel is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted while pixel pending");

  // A start beat never produces a pixel right after it.
  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_START) |=> !m_axis_tvalid)
    else $error("pixel after start beat");

  // No pixel is valid right after the final pixel of a line is taken.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("pixel after last");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled pixel changed");

endmodule

bind line_rasterizer_dda_bresenham_wu lrw_checker #(
  .OUT_W (OUT_W)
) u_lrw_checker (.*);

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import lrw_pkg::*;

  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  SETTLE      = 40;
  localparam int  ONE_FX      = 1 << 16;
  localparam int  FRAC_MASK   = ONE_FX - 1;
  localparam logic [MODE_W-1:0] MODE_ALT = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // delta_x, delta_y
  logic        s_axis_tuser;   // action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // pixel_x, pixel_y, intensity
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [MODE_W-1:0] cfg_data; // line_mode

  line_rasterizer_dda_bresenham_wu u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  typedef struct {
    logic [12:0] px;
    logic [12:0] py;
    logic [7:0]  level;
    logic        last;
  } pixel_t;

  class line_scoreboard;
    pixel_t pixels_due[$];
    int     mismatches;
    logic [MODE_W-1:0] mode;
    bit     active, x_major, minor_neg, minor_step_neg, major_neg;
    longint step_index, step_limit, primary_pos, secondary_pos;
    longint error_term, slope_frac, acc_x, acc_y, inc_x, inc_y;

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint to_int(longint a);
      return a < 0 ? -((-a) >>> 16) : a >>> 16;
    endfunction

    function longint slope_inc(longint d, longint len);
      longint m;
      m = ((mag(d) << 16) + len - 1) / len;
      return d < 0 ? -m : m;
    endfunction

    function void push_pixel(longint x, longint y, longint level, bit last);
      pixel_t p;
      p.px = x[12:0];
      p.py = y[12:0];
      p.level = level[7:0];
      p.last = last;
      pixels_due = {pixels_due, p};
    endfunction

    function void note_beat(bit act, logic signed [11:0] dx_in, logic signed [11:0] dy_in);
      longint dx, dy, len, dp, ds, p, s, f, off;
      bit last;
      dx = dx_in;
      dy = dy_in;
      if (act == ACT_START) begin
        len = mag(dx) >= mag(dy) ? mag(dx) : mag(dy);
        if (len == 0) begin
          active = 0;
          return;
        end
        x_major = mag(dx) >= mag(dy);
        dp = x_major ? dx : dy;
        ds = x_major ? dy : dx;
        inc_x = slope_inc(dx, len);
        inc_y = slope_inc(dy, len);
        acc_x = 0;
        acc_y = 0;
        slope_frac = (mag(ds) << 16) / len;
        error_term = slope_frac - (ONE_FX >> 1);
        major_neg = dp < 0;
        minor_step_neg = ds <= 0;
        minor_neg = ds < 0;
        primary_pos = 0;
        secondary_pos = 0;
        step_index = 0;
        step_limit = len;
        active = 1;
        return;
      end
      if (!active) return;
      acc_x += inc_x;
      acc_y += inc_y;
      if (mode == MODE_DDA || mode == MODE_ALT) begin
        last = step_index + 1 >= step_limit;
        push_pixel(to_int(acc_x), to_int(acc_y), 0, last);
      end else begin
        p = primary_pos;
        s = secondary_pos;
        last = step_index >= step_limit;
        f = mag(error_term) & FRAC_MASK;
        push_pixel(x_major ? p : s, x_major ? s : p,
                   mode == MODE_WU ? (255 * f) >>> 16 : 0, last);
        // Wu adds the coverage complement on the neighbor across the line.
        if (mode == MODE_WU && step_index != 0 && !last) begin
          off = (error_term >= 0) ? (minor_neg ? -1 : 1) : (minor_neg ? 1 : -1);
          push_pixel(x_major ? p : s + off, x_major ? s + off : p,
                     (255 * (ONE_FX - f)) >>> 16, 0);
        end
      end
      if (error_term >= 0) begin
        secondary_pos += minor_step_neg ? -1 : 1;
        error_term -= ONE_FX;
      end
      primary_pos += major_neg ? -1 : 1;
      error_term += slope_frac;
      step_index++;
      if (last) active = 0;
    endfunction

    function void check_pixel(logic [39:0] data, logic last);
      pixel_t e;
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel beat: data=%h last=%b", data, last);
        return;
      end
      e = pixels_due.pop_front();
      if (data[12:0] !== e.px || data[25:13] !== e.py || data[33:26] !== e.level ||
          last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: exp x=%0d y=%0d i=%0d l=%b got x=%0d y=%0d i=%0d l=%b",
                   $signed(e.px), $signed(e.py), e.level, e.last, $signed(data[12:0]),
                   $signed(data[25:13]), data[33:26], last);
      end
    endfunction

    function int outstanding();
      return pixels_due.size();
    endfunction
  endclass

  line_scoreboard sb;
  int  cycles;
  int  burst_left;
  bit  hold_req;

  initial begin
    clk = 0;
    cycles = 0;
    forever begin
      #5 clk = ~clk;
      if (clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_pixel(m_axis_tdata, m_axis_tlast);

  // Receiver: the stall pattern is redrawn at random from three patterns, with a single long hold-off.
  initial begin
    int pattern, count;
    m_axis_tready = 0;
    pattern = 0;
    count = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready = 0;
        repeat (300) @(negedge clk);
        hold_req = 0;
      end
      if (++count == 200) begin
        count = 0;
        pattern = $urandom_range(0, 2);
      end
      case (pattern)
        0: m_axis_tready = 1;
        1: m_axis_tready = $urandom_range(0, 9) < 7;
        default: m_axis_tready = $urandom_range(0, 9) < 3;
      endcase
    end
  end

  task automatic send_beat(bit act, logic [11:0] dx, logic [11:0] dy);
    if (burst_left == 0) begin
      s_axis_tvalid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    s_axis_tvalid = 1;
    s_axis_tdata = {dy, dx};
    s_axis_tuser = act;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_beat(act, dx, dy);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic step_beat();
    send_beat(ACT_STEP, 12'($urandom), 12'($urandom));
  endtask

  task automatic drain();
    s_axis_tvalid = 0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_mode(logic [MODE_W-1:0] m);
    drain();
    cfg_valid = 1;
    cfg_data = m;
    do @(posedge clk); while (!cfg_ready);
    sb.mode = m;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  initial begin
    logic [MODE_W-1:0] phase_modes [5];
    logic [11:0] dx, dy;
    int sent, steps, len, sel;
    bit hold_done, drain_done;
    sb = new();
    phase_modes = '{MODE_DDA, MODE_BRES, MODE_ALT, MODE_WU, MODE_DDA};
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = 0;
    cfg_valid = 0;
    cfg_data = '0;
    hold_req = 0;
    burst_left = 0;
    hold_done = 0;
    drain_done = 0;
    repeat (5) @(negedge clk);
    rst = 0;

    // Directed: idle step, zero-length start, extreme deltas, restart mid-line, short Wu line.
    write_mode(MODE_WU);
    step_beat();
    send_beat(ACT_START, 12'd0, 12'd0);
    step_beat();
    send_beat(ACT_START, 12'h7FF, 12'h800);
    repeat (3) step_beat();
    send_beat(ACT_START, 12'h800, 12'h7FF);
    repeat (2) step_beat();
    send_beat(ACT_START, -12'sd5, 12'sd3);
    repeat (6) step_beat();
    step_beat();

    sent = 0;
    for (int ph = 0; ph < 5; ph++) begin
      write_mode(phase_modes[ph]);
      while (sent < (ph + 1) * 300) begin
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
          step_beat();
          sent++;
          continue;
        end
        if (sel < 10) begin
          dx = 0;
          dy = 0;
        end else if (sel < 20) begin
          dx = 12'($urandom);
          dy = 12'($urandom);
        end else begin
          dx = 12'($urandom_range(0, 40) - 20);
          dy = 12'($urandom_range(0, 40) - 20);
        end
        send_beat(ACT_START, dx, dy);
        sent++;
        len = ($signed(dx) < 0 ? -$signed(dx) : $signed(dx));
        if (($signed(dy) < 0 ? -$signed(dy) : $signed(dy)) > len)
          len = ($signed(dy) < 0 ? -$signed(dy) : $signed(dy));
        // Long lines are cut short and dropped by the next start.
        if (len > 40 || $urandom_range(0, 4) == 0) steps = $urandom_range(0, 30);
        else steps = len + 1 + $urandom_range(0, 2);
        repeat (steps) begin
          step_beat();
          sent++;
          if (sent >= 300 && !hold_done) begin
            hold_req = 1;
            hold_done = 1;
          end
          if (sent >= 700 && !drain_done) begin
            drain();
            drain_done = 1;
          end
        end
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule

// File: sim.f
sv/lrw_pkg.sv
sv/lrw_ctrl.sv
sv/lrw_datapath.sv
sv/line_rasterizer_dda_bresenham_wu.sv
sv/lrw_checker.sv
sim/tb.sv
